[src/stereo_paint_mixer_defines.svh]
// Assertion macros used by the stereo paint mixer checker.
`ifndef STEREO_PAINT_MIXER_DEFINES_SVH
`define STEREO_PAINT_MIXER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SPM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/spm_pkg.sv]
// Types and constants of the stereo paint mixer.
package spm_pkg;

  localparam int SPM_PAINT_DEPTH = 512;

  localparam int SPM_SLOT_W   = 9;
  localparam int SPM_SAMPLE_W = 16;
  localparam int SPM_GAIN_W   = 9;
  localparam int SPM_VOL_W    = 10;
  localparam int SPM_ACC_W    = 32;
  localparam int SPM_OUT_W    = 16;
  localparam int SPM_IDX_W    = 2;

  localparam logic [SPM_VOL_W-1:0] SPM_VOL_RESET   = 10'd256;
  localparam logic [SPM_GAIN_W-1:0] SPM_GAIN8_MAX  = 9'd255;
  localparam int                   SPM_GAIN8_SHIFT = 3;
  localparam logic [SPM_OUT_W-1:0] SPM_CLIP_MAX    = 16'h7fff;
  localparam logic [SPM_OUT_W-1:0] SPM_CLIP_MIN    = 16'h8000;
  localparam logic [SPM_OUT_W-1:0] SPM_OFFSET8     = 16'd128;

  typedef enum logic {
    SPM_OP_MIX   = 1'b0,
    SPM_OP_DRAIN = 1'b1
  } spm_op_t;

  typedef enum logic [SPM_IDX_W-1:0] {
    SPM_REG_MASTER_VOL = 2'd0,
    SPM_REG_OUT_8BIT   = 2'd1,
    SPM_REG_OUT_MONO   = 2'd2
  } spm_reg_t;

  typedef struct packed {
    logic [SPM_VOL_W-1:0] master_volume;
    logic                 output_8bit;
    logic                 output_mono;
  } spm_cfg_t;

  typedef struct packed {
    logic [SPM_ACC_W-1:0] left;
    logic [SPM_ACC_W-1:0] right;
  } spm_acc_t;

endpackage

[src/spm_chan_if.sv]
// Channel interfaces: mix/drain input, result output, configuration writes.
interface spm_in_if import spm_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic                           op;
  logic [SPM_SLOT_W-1:0]          slot;
  logic signed [SPM_SAMPLE_W-1:0] sample;
  logic                           source_8bit;
  logic [SPM_GAIN_W-1:0]          left_gain;
  logic [SPM_GAIN_W-1:0]          right_gain;

  modport source (output valid, op, slot, sample, source_8bit, left_gain, right_gain,
                  input ready);
  modport sink (input valid, op, slot, sample, source_8bit, left_gain, right_gain,
                output ready);
endinterface

interface spm_out_if import spm_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [SPM_OUT_W-1:0] left_out;
  logic signed [SPM_OUT_W-1:0] right_out;

  modport source (output valid, left_out, right_out, input ready);
  modport sink (input valid, left_out, right_out, output ready);
endinterface

interface spm_cfg_if import spm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [SPM_IDX_W-1:0] index;
  logic [SPM_VOL_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[src/spm_store.sv]
// Paint store: one write port, one registered read port, left/right pair per entry.
module spm_store import spm_pkg::*; #(
  parameter int DEPTH  = SPM_PAINT_DEPTH,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  spm_acc_t          wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output spm_acc_t          rd_data
);

  spm_acc_t mem [DEPTH];
  spm_acc_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read-before-write: a same-edge write is not seen here
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[src/spm_outstage.sv]
// Drain output stage: holds drained sums; applies volume, clipping, 8-bit form, mono.
module spm_outstage import spm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  spm_cfg_t  cfg,
  input  logic      d_load,
  input  spm_acc_t  d_acc,
  output logic      d_ready,
  spm_out_if.source out_ch
);

  logic                 d_vld_r;
  spm_acc_t             d_acc_r;
  logic                 out_vld_r;
  logic [SPM_OUT_W-1:0] out_left_r;
  logic [SPM_OUT_W-1:0] out_right_r;
  logic                 out_free;
  logic [SPM_OUT_W-1:0] left_nxt;
  logic [SPM_OUT_W-1:0] right_nxt;

  function automatic logic [SPM_OUT_W-1:0] scale_side(logic [SPM_ACC_W-1:0] acc,
                                                      spm_cfg_t c);
    logic signed [SPM_ACC_W+SPM_VOL_W:0]   prod;
    logic signed [SPM_ACC_W+SPM_VOL_W-8:0] val;
    logic [SPM_OUT_W-1:0]                  clip;
    logic [SPM_OUT_W-1:0]                  off;
    prod = $signed(acc) * $signed({1'b0, c.master_volume});
    val  = prod[SPM_ACC_W+SPM_VOL_W:8];
    if (val > $signed({{(SPM_ACC_W+SPM_VOL_W-8-SPM_OUT_W+1){1'b0}}, SPM_CLIP_MAX})) begin
      clip = SPM_CLIP_MAX;
    end else if (val < $signed({{(SPM_ACC_W+SPM_VOL_W-8-SPM_OUT_W+1){1'b1}}, SPM_CLIP_MIN}))
    begin
      clip = SPM_CLIP_MIN;
    end else begin
      clip = val[SPM_OUT_W-1:0];
    end
    // 8-bit offset form: arithmetic high byte plus 128
    off = {{8{clip[SPM_OUT_W-1]}}, clip[SPM_OUT_W-1:8]} + SPM_OFFSET8;
    return c.output_8bit ? off : clip;
  endfunction

  assign out_free  = !out_vld_r || out_ch.ready;
  assign d_ready   = !d_vld_r || out_free;
  assign left_nxt  = scale_side(d_acc_r.left, cfg);
  assign right_nxt = cfg.output_mono ? '0 : scale_side(d_acc_r.right, cfg);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (d_ready) begin
        d_vld_r <= d_load;
      end
      if (out_free) begin
        out_vld_r <= d_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready && d_load) begin
      d_acc_r <= d_acc;
    end
    if (out_free && d_vld_r) begin
      out_left_r  <= left_nxt;
      out_right_r <= right_nxt;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.left_out  = $signed(out_left_r);
  assign out_ch.right_out = $signed(out_right_r);

endmodule

[src/stereo_paint_mixer.sv]
// Stereo paint mixer top level: input stage, store read-modify-write, config, clear.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        op, slot, sample, source_8bit, left_gain, right_gain
//   out_ch   out  valid/ready        left_out, right_out
//   cfg_ch   in   valid/ready (=1)   index, data
//
// One item per cycle while in_ch.ready is high: one read-modify-write per in-range item.
// A drain result passes the input, drain and output registers on its way to out_ch.
// After reset a clearing pass zeroes every store entry; in_ch.ready is low meanwhile.
// A stalled out_ch holds its result; drains back up through the drain register into
// in_ch.ready, while mix transactions keep flowing as long as the input stage is free.
module stereo_paint_mixer import spm_pkg::*; #(
  parameter int PAINT_DEPTH = SPM_PAINT_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  spm_in_if.sink    in_ch,
  spm_out_if.source out_ch,
  spm_cfg_if.sink   cfg_ch
);

  localparam int              AW   = $clog2(PAINT_DEPTH);
  localparam logic [AW-1:0]   LAST = AW'(PAINT_DEPTH - 1);

  spm_cfg_t cfg_r;

  logic          clr_busy_r;
  logic [AW-1:0] clr_cnt_r;

  logic                           s1_vld_r;
  spm_op_t                        s1_op_r;
  logic                           s1_ok_r;
  logic [AW-1:0]                  s1_addr_r;
  logic signed [SPM_SAMPLE_W-1:0] s1_sample_r;
  logic                           s1_src8_r;
  logic [SPM_GAIN_W-1:0]          s1_lg_r;
  logic [SPM_GAIN_W-1:0]          s1_rg_r;
  logic                           byp_hit_r;
  spm_acc_t                       byp_data_r;

  logic          in_acc;
  logic          slot_ok;
  logic [AW-1:0] rd_addr;
  spm_acc_t      rd_data;
  spm_acc_t      acc_cur;
  spm_acc_t      mix_sum;
  logic          s1_go;
  logic          s1_free;
  logic          d_ready;
  logic          d_load;
  spm_acc_t      d_acc;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  spm_acc_t      wr_data;

  function automatic logic [SPM_ACC_W-1:0] mix_term(logic signed [SPM_SAMPLE_W-1:0] smp,
                                                    logic [SPM_GAIN_W-1:0] gain,
                                                    logic src8);
    logic [SPM_GAIN_W-1:0]          g8;
    logic signed [SPM_SAMPLE_W-1:0] a;
    logic signed [SPM_GAIN_W:0]     b;
    logic signed [SPM_SAMPLE_W+SPM_GAIN_W:0] p;
    g8 = (gain > SPM_GAIN8_MAX) ? SPM_GAIN8_MAX : gain;
    if (src8) begin
      // 8-bit rule: s8 * (g >> 3) * 8 with g clamped to 255, done as one product
      a = {{8{smp[7]}}, smp[7:0]};
      b = $signed({1'b0, (g8 >> SPM_GAIN8_SHIFT) << SPM_GAIN8_SHIFT});
    end else begin
      a = smp;
      b = $signed({1'b0, gain});
    end
    p = a * b;
    if (src8) begin
      return {{(SPM_ACC_W-SPM_SAMPLE_W-SPM_GAIN_W-1){p[SPM_SAMPLE_W+SPM_GAIN_W]}}, p};
    end
    return {{(SPM_ACC_W-SPM_SAMPLE_W-SPM_GAIN_W+7){p[SPM_SAMPLE_W+SPM_GAIN_W]}},
            p[SPM_SAMPLE_W+SPM_GAIN_W:8]};
  endfunction

  // configuration
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.master_volume <= SPM_VOL_RESET;
      cfg_r.output_8bit   <= 1'b0;
      cfg_r.output_mono   <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        SPM_REG_MASTER_VOL: cfg_r.master_volume <= cfg_ch.data;
        SPM_REG_OUT_8BIT:   cfg_r.output_8bit   <= cfg_ch.data[0];
        SPM_REG_OUT_MONO:   cfg_r.output_mono   <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // input stage
  assign s1_go   = s1_vld_r && (s1_op_r == SPM_OP_MIX || d_ready);
  assign s1_free = !s1_vld_r || s1_go;
  assign in_ch.ready = !clr_busy_r && s1_free;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign slot_ok = 32'(in_ch.slot) < 32'(PAINT_DEPTH);
  assign rd_addr = AW'(in_ch.slot);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
      s1_vld_r   <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (s1_free) begin
        s1_vld_r <= in_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r     <= spm_op_t'(in_ch.op);
      s1_ok_r     <= slot_ok;
      s1_addr_r   <= rd_addr;
      s1_sample_r <= in_ch.sample;
      s1_src8_r   <= in_ch.source_8bit;
      s1_lg_r     <= in_ch.left_gain;
      s1_rg_r     <= in_ch.right_gain;
      // entry written on the same edge as this read: take the new value
      byp_hit_r   <= wr_en && (wr_addr == rd_addr);
      byp_data_r  <= wr_data;
    end
  end

  // read-modify-write
  assign acc_cur       = byp_hit_r ? byp_data_r : rd_data;
  assign mix_sum.left  = acc_cur.left + mix_term(s1_sample_r, s1_lg_r, s1_src8_r);
  assign mix_sum.right = acc_cur.right + mix_term(s1_sample_r, s1_rg_r, s1_src8_r);

  always_comb begin
    if (clr_busy_r) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r;
      wr_data = '0;
    end else begin
      wr_en   = s1_go && s1_ok_r;
      wr_addr = s1_addr_r;
      wr_data = (s1_op_r == SPM_OP_MIX) ? mix_sum : '0;
    end
  end

  assign d_load = s1_go && (s1_op_r == SPM_OP_DRAIN);
  assign d_acc  = s1_ok_r ? acc_cur : '0;

  spm_store #(
    .DEPTH  (PAINT_DEPTH),
    .ADDR_W (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_acc),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  spm_outstage u_outstage (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .d_load  (d_load),
    .d_acc   (d_acc),
    .d_ready (d_ready),
    .out_ch  (out_ch)
  );

endmodule

[src/spm_checker.sv]
// Port-level checker for the stereo paint mixer, bound to the top level.
`include "stereo_paint_mixer_defines.svh"

module spm_checker import spm_pkg::*; (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_op,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic signed [SPM_OUT_W-1:0] left_out,
  input logic signed [SPM_OUT_W-1:0] right_out,
  input logic                        cfg_valid,
  input logic                        cfg_ready,
  input logic [SPM_IDX_W-1:0]        cfg_index,
  input logic [SPM_VOL_W-1:0]        cfg_data
);

  logic       mono_r;
  logic       out8_r;
  logic [2:0] pend_r;
  logic [2:0] pend_nxt;
  logic       drain_acc;
  logic       out_acc;

  assign drain_acc = in_valid && in_ready && (in_op == SPM_OP_DRAIN);
  assign out_acc   = out_valid && out_ready;
  assign pend_nxt  = pend_r + {2'b00, drain_acc} - {2'b00, out_acc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mono_r <= 1'b0;
      out8_r <= 1'b0;
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
      if (cfg_valid && cfg_ready && cfg_index == SPM_REG_OUT_MONO) begin
        mono_r <= cfg_data[0];
      end
      if (cfg_valid && cfg_ready && cfg_index == SPM_REG_OUT_8BIT) begin
        out8_r <= cfg_data[0];
      end
    end
  end

  `SPM_ASSERT_NOW(a_result_has_drain, out_valid, pend_r != 3'd0, "result without drain")
  `SPM_ASSERT_NOW(a_mono_right_zero, out_valid && mono_r, right_out == 16'sd0, "mono right")
  `SPM_ASSERT_NOW(a_8bit_range, out_valid && out8_r, left_out[15:8] == 8'h00 && right_out[15:8] == 8'h00, "8-bit range")
  `SPM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(left_out) && $stable(right_out), "stalled result changed")

endmodule

bind stereo_paint_mixer spm_checker u_spm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_op     (in_ch.op),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .left_out  (out_ch.left_out),
  .right_out (out_ch.right_out),
  .cfg_valid (cfg_ch.valid),
  .cfg_ready (cfg_ch.ready),
  .cfg_index (cfg_ch.index),
  .cfg_data  (cfg_ch.data)
);
